// ===== sv/bounded_set_min_max_gap_defines.svh =====
// Assertion macros used by the RTL.
`ifndef BOUNDED_SET_MIN_MAX_GAP_DEFINES_SVH
`define BOUNDED_SET_MIN_MAX_GAP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define BSMG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bounded set check failed");
// Check a property at every rising edge, reset included.
`define BSMG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("bounded set check failed");
`else
`define BSMG_ASSERT(lbl, clk, rst, prop)
`define BSMG_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/bsmg_pkg.sv =====
`default_nettype none
package bsmg_pkg;

  localparam int DATA_W  = 32;
  localparam int CAP_W   = 6;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd20;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_FEW  = 2'd2;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] shortest_span;
    logic [DATA_W-1:0] longest_span;
  } rsp_t;

endpackage
`default_nettype wire

// ===== sv/bsmg_ram.sv =====
`default_nettype none
module bsmg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/bounded_set_min_max_gap.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  bsmg_pkg::req_t (mode, value)
// rsp       out        rsp_valid / rsp_ready  bsmg_pkg::rsp_t (status, spans)
// apb       in/out     psel, penable, pready  capacity at byte address 0
//
// An add walks the sorted store down from the top entry, shifting each stored
// value above the new one up a slot; a query scans every stored value. A full
// or too-few request goes straight to the result. The time taken is set by the
// sorted store, one RAM port walked one entry a cycle, and by the one 33-bit
// subtractor that does the insert compares and the scan differences. rst is
// synchronous, active high; it empties the set and sets capacity to 20. A result
// waiting on rsp_ready does not block the next request; only the next result waits behind it.
`default_nettype none
`include "bounded_set_min_max_gap_defines.svh"
module bounded_set_min_max_gap #(
  parameter int MAX_DEPTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire bsmg_pkg::req_t                req,
  output logic                               rsp_valid,
  input  wire logic                          rsp_ready,
  output bsmg_pkg::rsp_t                     rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bsmg_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bsmg_pkg::PDATA_W-1:0]  pwdata,
  output logic      [bsmg_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import bsmg_pkg::*;

  localparam int AW   = $clog2(MAX_DEPTH);
  localparam int CW   = $clog2(MAX_DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b000_0001,
    S_INS_CMP  = 7'b000_0010,
    S_INS_LAST = 7'b000_0100,
    S_Q_FIRST  = 7'b000_1000,
    S_Q_SCAN   = 7'b001_0000,
    S_Q_RANGE  = 7'b010_0000,
    S_DONE     = 7'b100_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CAP_W-1:0]         capacity;
  logic [CW-1:0]            count;
  logic [CW-1:0]            pos;        // slot being opened during an insert
  logic [AW-1:0]            idx;        // address whose data sits in rdata during a scan
  logic signed [DATA_W-1:0] value;      // value being inserted
  logic signed [DATA_W-1:0] first;      // smallest stored value
  logic signed [DATA_W-1:0] prev;       // previous value of the scan
  logic [DATA_W-1:0]        best;       // shortest gap so far
  logic [DATA_W-1:0]        longest;
  logic [1:0]               res_status;

  // RAM port signals
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Shared 33-bit subtractor: compares for the insert, differences for the scan
  logic signed [DATA_W-1:0] sub_a;
  logic signed [DATA_W-1:0] sub_b;
  logic [DATA_W:0]          diff;

  logic          set_full;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] pos_m2;
  logic          req_fire;

  //--------------------------------------------------------------------------
  // Configuration port: capacity is the only register
  //--------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = PDATA_W'(capacity);
    end
  end

  //--------------------------------------------------------------------------
  // Store
  //--------------------------------------------------------------------------
  bsmg_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  //--------------------------------------------------------------------------
  // Sequencer
  //--------------------------------------------------------------------------
  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign count_m1  = count - CW'(1);
  assign pos_m2    = pos - CW'(2);

  // Full once count reaches the configured capacity or the store depth
  assign set_full = (CMPW'(count) >= CMPW'(capacity)) || (count == CW'(MAX_DEPTH));

  assign diff = {sub_a[DATA_W-1], sub_a} - {sub_b[DATA_W-1], sub_b};

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = pos[AW-1:0];
    ram_wdata  = value;
    ram_raddr  = '0;
    sub_a      = ram_rdata;
    sub_b      = prev;
    unique case (state)
      S_IDLE: begin
        // Start the read of the top entry; a query starts at address zero
        if (req.mode == MODE_ADD) begin
          ram_raddr = count_m1[AW-1:0];
        end
        if (req_fire) begin
          if (req.mode == MODE_ADD) begin
            if (set_full) begin
              state_next = S_DONE;
            end else if (count == '0) begin
              state_next = S_INS_LAST;
            end else begin
              state_next = S_INS_CMP;
            end
          end else begin
            if (count < CW'(2)) begin
              state_next = S_DONE;
            end else begin
              state_next = S_Q_FIRST;
            end
          end
        end
      end
      S_INS_CMP: begin
        // rdata holds entry pos-1; shift it up while it is above the new value
        sub_a = value;
        sub_b = ram_rdata;
        ram_we = 1'b1;
        if (diff[DATA_W]) begin
          ram_wdata = ram_rdata;
          ram_raddr = pos_m2[AW-1:0];
          if (pos == CW'(1)) begin
            state_next = S_INS_LAST;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_INS_LAST: begin
        ram_we     = 1'b1;
        state_next = S_DONE;
      end
      S_Q_FIRST: begin
        ram_raddr  = AW'(1);
        state_next = S_Q_SCAN;
      end
      S_Q_SCAN: begin
        ram_raddr = idx + AW'(1);
        if (CW'(idx) == count_m1) begin
          state_next = S_Q_RANGE;
        end
      end
      S_Q_RANGE: begin
        sub_a      = prev;
        sub_b      = first;
        state_next = S_DONE;
      end
      S_DONE: begin
        // Hold here only while the previous result is still unclaimed
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if ((state == S_INS_LAST) || ((state == S_INS_CMP) && !diff[DATA_W])) begin
        count <= count + CW'(1);
      end
    end
  end

  // Working registers need no reset
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          value   <= req.value;
          pos     <= count;
          best    <= '0;
          longest <= '0;
          if (req.mode == MODE_ADD) begin
            res_status <= set_full ? ST_FULL : ST_OK;
          end else begin
            res_status <= (count < CW'(2)) ? ST_FEW : ST_OK;
          end
        end
      end
      S_INS_CMP: begin
        if (diff[DATA_W]) begin
          pos <= pos - CW'(1);
        end
      end
      S_Q_FIRST: begin
        first <= ram_rdata;
        prev  <= ram_rdata;
        best  <= '1;
        idx   <= AW'(1);
      end
      S_Q_SCAN: begin
        prev <= ram_rdata;
        idx  <= idx + AW'(1);
        if (diff[DATA_W-1:0] < best) begin
          best <= diff[DATA_W-1:0];
        end
      end
      S_Q_RANGE: begin
        longest <= diff[DATA_W-1:0];
      end
      default: begin
      end
    endcase
  end

  //--------------------------------------------------------------------------
  // Output register
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
      rsp.status        <= res_status;
      rsp.shortest_span <= best;
      rsp.longest_span  <= longest;
    end
  end

  //--------------------------------------------------------------------------
  // Checks
  //--------------------------------------------------------------------------
  `BSMG_ASSERT(a_count_bound, clk, rst, count <= CW'(MAX_DEPTH))
  `BSMG_ASSERT(a_count_step, clk, rst, (!$past(rst) && (count != $past(count))) |-> (count == ($past(count) + CW'(1))))
  `BSMG_ASSERT(a_write_in_range, clk, rst, ram_we |-> (CW'(ram_waddr) <= count))
  `BSMG_ASSERT(a_range_covers_gap, clk, rst, (rsp_valid && (rsp.status == ST_OK)) |-> (rsp.longest_span >= rsp.shortest_span))

endmodule
`default_nettype wire
